// ----- hw/rtl/mbb_pkg.sv -----
// Package: shared types and constants for the masked 3x3 box blur.
`timescale 1ns / 1ps

package mbb_pkg;

    localparam int SIZE_W       = 11;
    localparam int CHAN_W       = 16;
    localparam int SUM_W        = 20;
    localparam int MULT_W       = 21;
    localparam int PROD_W       = SUM_W + MULT_W;
    localparam int MAX_SIZE_DEF = 1024;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // reciprocals: x/9 = (x*R9)>>24, x/3 = (x*R3)>>21, x/4 = (x*R4)>>21
    localparam logic [MULT_W-1:0] RECIP_9 = 21'd1864136;
    localparam logic [MULT_W-1:0] RECIP_3 = 21'd699051;
    localparam logic [MULT_W-1:0] RECIP_4 = 21'd524288;
    localparam int SHIFT_9  = 24;
    localparam int SHIFT_34 = 21;

    typedef struct packed {
        logic              keep;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        pix_t upper;
        pix_t lower;
    } line_t;

    // output position info travelling with an item
    typedef struct packed {
        logic pend;
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } pos_t;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } div_cls_t;

endpackage

// ----- hw/rtl/mbb_if.sv -----
// Interfaces: pixel input, result output and size configuration channels.
`timescale 1ns / 1ps

interface mbb_pix_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [mbb_pkg::CHAN_W-1:0] red_in;
    logic [mbb_pkg::CHAN_W-1:0] green_in;
    logic [mbb_pkg::CHAN_W-1:0] blue_in;
    logic                      keep;

    modport source (output valid, func, red_in, green_in, blue_in, keep, input ready);
    modport sink   (input valid, func, red_in, green_in, blue_in, keep, output ready);
endinterface

interface mbb_res_if;
    logic                      valid;
    logic                      ready;
    logic [mbb_pkg::CHAN_W-1:0] red_out;
    logic [mbb_pkg::CHAN_W-1:0] green_out;
    logic [mbb_pkg::CHAN_W-1:0] blue_out;
    logic                      frame_last;

    modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

interface mbb_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [mbb_pkg::SIZE_W-1:0] image_size;

    modport source (output valid, image_size, input ready);
    modport sink   (input valid, image_size, output ready);
endinterface

// ----- hw/rtl/masked_box_blur_3x3.sv -----
// Top level: masked 3x3 box blur over a square RGB frame.
// Throughput: one beat per cycle unless the result side stalls; line stores are one RAM read and written once per beat.
// Order: a pixel's result is formed once the beat that lies image_size + 1 beats behind it is
// accepted, and passes through read, window shift, neighborhood sum and reciprocal divide.
// Reset: position counters zero, image_size 1024; line stores are not cleared.
`timescale 1ns / 1ps

module masked_box_blur_3x3 #(
    parameter int MAX_SIZE = mbb_pkg::MAX_SIZE_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mbb_cfg_if.sink   cfg,
    mbb_pix_if.sink   pix,
    mbb_res_if.source res
);

    localparam int CW    = $clog2(MAX_SIZE);
    localparam int NW    = $clog2(MAX_SIZE + 1);
    localparam int RW    = $clog2(MAX_SIZE + 2);
    localparam int CMP_W = (NW > mbb_pkg::SIZE_W) ? NW : mbb_pkg::SIZE_W;

    function automatic logic [NW-1:0] clamp_size(input logic [mbb_pkg::SIZE_W-1:0] s);
        logic [CMP_W-1:0] sx;
        logic [NW-1:0]    r;
        sx = CMP_W'(s);
        if (sx < CMP_W'(2))
            r = NW'(2);
        else if (sx > CMP_W'(MAX_SIZE))
            r = NW'(MAX_SIZE);
        else
            r = NW'(sx);
        return r;
    endfunction

    // frame position
    logic [NW-1:0] n_reg,       n_next;
    logic [CW-1:0] nm1_reg,     nm1_next;
    logic [CW-1:0] in_col_reg,  in_col_next;
    logic [RW-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [CW-1:0] out_row_reg, out_row_next;
    logic [NW-1:0] n_cfg;

    logic          cfg_wr;
    logic          accept;
    logic          draining;
    logic          take;
    logic          pending;
    logic          in_last_col;
    mbb_pkg::pix_t in_word;
    mbb_pkg::pos_t in_pos;

    // stage 1: line read
    logic          s1_v_reg, s1_v_next;
    mbb_pkg::pix_t s1_word_reg;
    logic [CW-1:0] s1_col_reg;
    mbb_pkg::pos_t s1_pos_reg;
    logic          s1_go, s1_free;
    mbb_pkg::line_t line_rd;
    mbb_pkg::line_t line_wr;

    // stage 2: window
    mbb_pkg::pix_t win_reg [3][3];
    logic          s2_v_reg, s2_v_next;
    mbb_pkg::pos_t s2_pos_reg;
    logic          s2_go, s2_free;
    logic [2:0]    row_ok;
    logic [2:0]    col_ok;
    logic [mbb_pkg::SUM_W-1:0] sum_r, sum_g, sum_b;
    mbb_pkg::div_cls_t cls;

    // stage 3: divide
    logic          s3_v_reg, s3_v_next;
    logic [mbb_pkg::SUM_W-1:0] s3_sum_r_reg, s3_sum_g_reg, s3_sum_b_reg;
    mbb_pkg::div_cls_t s3_cls_reg;
    mbb_pkg::pix_t s3_center_reg;
    logic          s3_last_reg;
    logic          s3_go, s3_free;
    logic [mbb_pkg::CHAN_W-1:0] q_r, q_g, q_b;

    // stage 4: output
    logic          s4_v_reg, s4_v_next;
    logic [mbb_pkg::CHAN_W-1:0] s4_r_reg, s4_g_reg, s4_b_reg;
    logic          s4_last_reg;
    logic          s4_free;

    // ---- input side ----
    assign cfg.ready   = 1'b1;
    assign cfg_wr      = cfg.valid && cfg.ready;
    assign n_cfg       = clamp_size(cfg.image_size);
    assign pix.ready   = s1_free;
    assign accept      = pix.valid && pix.ready;
    assign draining    = in_row_reg >= RW'(n_reg);
    assign take        = accept && (draining || pix.func == mbb_pkg::FUNC_PIXEL);
    assign in_last_col = in_col_reg == nm1_reg;
    assign pending     = !((in_row_reg == '0) ||
                           (in_row_reg == RW'(1) && in_col_reg == '0));

    always_comb
    begin
        if (draining)
        begin
            in_word = '0;
        end
        else
        begin
            in_word.keep  = pix.keep;
            in_word.red   = pix.red_in;
            in_word.green = pix.green_in;
            in_word.blue  = pix.blue_in;
        end
    end

    always_comb
    begin
        in_pos.pend   = pending;
        in_pos.top    = out_row_reg == '0;
        in_pos.bottom = out_row_reg == nm1_reg;
        in_pos.left   = out_col_reg == '0;
        in_pos.right  = out_col_reg == nm1_reg;
        in_pos.last   = (out_row_reg == nm1_reg) && (out_col_reg == nm1_reg);
    end

    always_comb
    begin
        n_next       = n_reg;
        nm1_next     = nm1_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_wr)
        begin
            n_next       = n_cfg;
            nm1_next     = CW'(n_cfg - NW'(1));
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (take)
        begin
            if (in_last_col)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (pending)
            begin
                if (in_pos.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (in_pos.right)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + CW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= clamp_size(mbb_pkg::SIZE_RESET);
            nm1_reg     <= CW'(clamp_size(mbb_pkg::SIZE_RESET) - NW'(1));
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            n_reg       <= n_next;
            nm1_reg     <= nm1_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---- pipeline control ----
    assign s4_free = !s4_v_reg || res.ready;
    assign s3_go   = s3_v_reg && s4_free;
    assign s3_free = !s3_v_reg || s3_go;
    assign s2_go   = s2_v_reg && (!s2_pos_reg.pend || s3_free);
    assign s2_free = !s2_v_reg || s2_go;
    assign s1_go   = s1_v_reg && s2_free;
    assign s1_free = !s1_v_reg || s1_go;

    assign s1_v_next = take ? 1'b1 : (s1_go ? 1'b0 : s1_v_reg);
    assign s2_v_next = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_v_reg);
    assign s3_v_next = (s2_go && s2_pos_reg.pend) ? 1'b1 : (s3_go ? 1'b0 : s3_v_reg);
    assign s4_v_next = s3_go ? 1'b1 : ((s4_v_reg && res.ready) ? 1'b0 : s4_v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
            s3_v_reg <= s3_v_next;
            s4_v_reg <= s4_v_next;
        end
    end

    // ---- stage 1: line stores ----
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_word_reg <= in_word;
            s1_col_reg  <= in_col_reg;
            s1_pos_reg  <= in_pos;
        end
    end

    assign line_wr.upper = line_rd.lower;
    assign line_wr.lower = s1_word_reg;

    mbb_line_mem #(
        .DEPTH (MAX_SIZE),
        .AW    (CW),
        .DW    ($bits(mbb_pkg::line_t))
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    // ---- stage 2: window and neighborhood sum ----
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= line_rd.upper;
            win_reg[1][2] <= line_rd.lower;
            win_reg[2][2] <= s1_word_reg;
            s2_pos_reg    <= s1_pos_reg;
        end
    end

    assign row_ok = {!s2_pos_reg.bottom, 1'b1, !s2_pos_reg.top};
    assign col_ok = {!s2_pos_reg.right, 1'b1, !s2_pos_reg.left};

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (row_ok[i] && col_ok[j])
                begin
                    sum_r = sum_r + mbb_pkg::SUM_W'(win_reg[i][j].red);
                    sum_g = sum_g + mbb_pkg::SUM_W'(win_reg[i][j].green);
                    sum_b = sum_b + mbb_pkg::SUM_W'(win_reg[i][j].blue);
                end
            end
        end
    end

    always_comb
    begin
        if ((s2_pos_reg.top || s2_pos_reg.bottom) && (s2_pos_reg.left || s2_pos_reg.right))
            cls = mbb_pkg::DIV_BY_4;
        else if (s2_pos_reg.top || s2_pos_reg.bottom || s2_pos_reg.left || s2_pos_reg.right)
            cls = mbb_pkg::DIV_BY_6;
        else
            cls = mbb_pkg::DIV_BY_9;
    end

    // ---- stage 3: divide ----
    always_ff @(posedge clk)
    begin
        if (s2_go && s2_pos_reg.pend)
        begin
            s3_sum_r_reg  <= sum_r;
            s3_sum_g_reg  <= sum_g;
            s3_sum_b_reg  <= sum_b;
            s3_cls_reg    <= cls;
            s3_center_reg <= win_reg[1][1];
            s3_last_reg   <= s2_pos_reg.last;
        end
    end

    mbb_div u_div_r (.sum(s3_sum_r_reg), .cls(s3_cls_reg), .quot(q_r));
    mbb_div u_div_g (.sum(s3_sum_g_reg), .cls(s3_cls_reg), .quot(q_g));
    mbb_div u_div_b (.sum(s3_sum_b_reg), .cls(s3_cls_reg), .quot(q_b));

    // ---- stage 4: output register ----
    always_ff @(posedge clk)
    begin
        if (s3_go)
        begin
            s4_r_reg    <= s3_center_reg.keep ? s3_center_reg.red   : q_r;
            s4_g_reg    <= s3_center_reg.keep ? s3_center_reg.green : q_g;
            s4_b_reg    <= s3_center_reg.keep ? s3_center_reg.blue  : q_b;
            s4_last_reg <= s3_last_reg;
        end
    end

    assign res.valid      = s4_v_reg;
    assign res.red_out    = s4_r_reg;
    assign res.green_out  = s4_g_reg;
    assign res.blue_out   = s4_b_reg;
    assign res.frame_last = s4_last_reg;

endmodule

// ----- hw/rtl/mbb_line_mem.sv -----
// Line store: synchronous RAM, registered read, with write-to-read forwarding.
`timescale 1ns / 1ps

module mbb_line_mem #(
    parameter int DEPTH = mbb_pkg::MAX_SIZE_DEF,
    parameter int AW    = $clog2(mbb_pkg::MAX_SIZE_DEF),
    parameter int DW    = $bits(mbb_pkg::line_t)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_q_reg;
    logic [DW-1:0] fwd_data_reg;
    logic          fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_q_reg;

endmodule

// ----- hw/rtl/mbb_div.sv -----
// Divider by 4, 6 or 9 through reciprocal multiplication, one channel.
`timescale 1ns / 1ps

module mbb_div (
    input  logic [mbb_pkg::SUM_W-1:0]  sum,
    input  mbb_pkg::div_cls_t          cls,
    output logic [mbb_pkg::CHAN_W-1:0] quot
);

    logic [mbb_pkg::SUM_W-1:0]  opnd;
    logic [mbb_pkg::MULT_W-1:0] mult;
    logic [mbb_pkg::PROD_W-1:0] prod;

    always_comb
    begin
        case (cls)
            mbb_pkg::DIV_BY_9:
            begin
                opnd = sum;
                mult = mbb_pkg::RECIP_9;
            end
            mbb_pkg::DIV_BY_6:
            begin
                opnd = sum >> 1;
                mult = mbb_pkg::RECIP_3;
            end
            default:
            begin
                opnd = sum;
                mult = mbb_pkg::RECIP_4;
            end
        endcase
    end

    assign prod = mbb_pkg::PROD_W'(opnd) * mbb_pkg::PROD_W'(mult);

    always_comb
    begin
        case (cls)
            mbb_pkg::DIV_BY_9: quot = prod[mbb_pkg::SHIFT_9 +: mbb_pkg::CHAN_W];
            default:           quot = prod[mbb_pkg::SHIFT_34 +: mbb_pkg::CHAN_W];
        endcase
    end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench: masked 3x3 box blur, random and directed frames checked beat by beat.
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES      = 400000;
    localparam int SETTLE_CYCLES     = 20;
    localparam int HOLD_CYCLES       = 200;
    localparam int BEATS_PER_STRETCH = 150;
    localparam int WIDE_BEATS        = 60;

    typedef struct packed {
        logic [mbb_pkg::CHAN_W-1:0] red;
        logic [mbb_pkg::CHAN_W-1:0] green;
        logic [mbb_pkg::CHAN_W-1:0] blue;
        logic                       last;
    } res_pix_t;

    class blur_board;
        mbb_pkg::pix_t              upper_mem[mbb_pkg::MAX_SIZE_DEF];
        mbb_pkg::pix_t              lower_mem[mbb_pkg::MAX_SIZE_DEF];
        mbb_pkg::pix_t              win[9];
        int unsigned                in_col, in_row, out_col, out_row;
        logic [mbb_pkg::SIZE_W-1:0] size_reg;
        res_pix_t                   blurred_q[$];
        int                         errors, beats, ignored, checked, frames;

        function new();
            foreach (upper_mem[i])
            begin
                upper_mem[i] = '0;
                lower_mem[i] = '0;
            end
            size_reg = mbb_pkg::SIZE_RESET;
            set_size(mbb_pkg::SIZE_RESET);
        endfunction

        function int unsigned side();
            if (size_reg < 2)
                return 2;
            if (size_reg > mbb_pkg::MAX_SIZE_DEF)
                return mbb_pkg::MAX_SIZE_DEF;
            return 32'(size_reg);
        endfunction

        // a size write restarts the frame and clears the window
        function void set_size(logic [mbb_pkg::SIZE_W-1:0] v);
            size_reg = v;
            foreach (win[i])
                win[i] = '0;
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function void accept_beat(logic func, mbb_pkg::pix_t p);
            int unsigned   n, c, pos, sum_r, sum_g, sum_b, cnt;
            int            rr, cc;
            mbb_pkg::pix_t word, ctr;
            mbb_pkg::pix_t col[3];
            res_pix_t      o;
            n    = side();
            word = '0;
            if (in_row < n)
            begin
                if (func == mbb_pkg::FUNC_DRAIN)
                begin
                    ignored++;
                    return;
                end
                word = p;
            end
            c      = in_col;
            col[0] = upper_mem[c];
            col[1] = lower_mem[c];
            col[2] = word;
            upper_mem[c] = col[1];
            lower_mem[c] = col[2];
            for (int r = 0; r < 3; r++)
            begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
                win[r*3+2] = col[r];
            end
            pos = in_row * n + in_col;
            beats++;
            in_col++;
            if (in_col >= n)
            begin
                in_col = 0;
                in_row++;
            end
            if (pos < n + 1)
                return;

            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            cnt   = 0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    rr = int'(out_row) - 1 + i;
                    cc = int'(out_col) - 1 + j;
                    if (rr >= 0 && rr < int'(n) && cc >= 0 && cc < int'(n))
                    begin
                        sum_r += 32'(win[i*3+j].red);
                        sum_g += 32'(win[i*3+j].green);
                        sum_b += 32'(win[i*3+j].blue);
                        cnt++;
                    end
                end
            end
            ctr = win[4];
            if (ctr.keep)
            begin
                o.red   = ctr.red;
                o.green = ctr.green;
                o.blue  = ctr.blue;
            end
            else
            begin
                o.red   = mbb_pkg::CHAN_W'(sum_r / cnt);
                o.green = mbb_pkg::CHAN_W'(sum_g / cnt);
                o.blue  = mbb_pkg::CHAN_W'(sum_b / cnt);
            end
            o.last = (out_row == n - 1) && (out_col == n - 1);
            blurred_q.push_back(o);

            out_col++;
            if (out_col >= n)
            begin
                out_col = 0;
                out_row++;
            end
            if (out_row >= n)
            begin
                in_col  = 0;
                in_row  = 0;
                out_col = 0;
                out_row = 0;
            end
        endfunction

        function void cmp_field(string what, logic [mbb_pkg::CHAN_W-1:0] want,
                                logic [mbb_pkg::CHAN_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            end
        endfunction

        function void check_output(res_pix_t got);
            res_pix_t want;
            if (blurred_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h %h %h last %b",
                         $time, got.red, got.green, got.blue, got.last);
                return;
            end
            want = blurred_q.pop_front();
            checked++;
            if (want.last)
                frames++;
            cmp_field("red", want.red, got.red);
            cmp_field("green", want.green, got.green);
            cmp_field("blue", want.blue, got.blue);
            cmp_field("frame_last", mbb_pkg::CHAN_W'(want.last), mbb_pkg::CHAN_W'(got.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle;
    int   snk_idle;
    int   hold_left = 0;
    int   cycle_cnt = 0;

    blur_board board = new();

    mbb_cfg_if cfg_ch();
    mbb_pix_if pix_ch();
    mbb_res_if res_ch();

    masked_box_blur_3x3 i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .pix   (pix_ch),
        .res   (res_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, board.blurred_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                board.set_size(cfg_ch.image_size);
            if (res_ch.valid && res_ch.ready)
                board.check_output({res_ch.red_out, res_ch.green_out, res_ch.blue_out,
                                    res_ch.frame_last});
            if (pix_ch.valid && pix_ch.ready)
                board.accept_beat(pix_ch.func, {pix_ch.keep, pix_ch.red_in, pix_ch.green_in,
                                                pix_ch.blue_in});
        end
    end

    // result side: long hold when requested, else random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_ch.ready = 1'b0;
            hold_left--;
        end
        else
            res_ch.ready = ($urandom_range(99) >= snk_idle);
    end

    function automatic logic [mbb_pkg::CHAN_W-1:0] rand_chan();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return mbb_pkg::CHAN_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic mbb_pkg::pix_t rand_pixel();
        mbb_pkg::pix_t p;
        p.keep  = ($urandom_range(3) == 0);
        p.red   = rand_chan();
        p.green = rand_chan();
        p.blue  = rand_chan();
        return p;
    endfunction

    task automatic send_item(input logic f, input mbb_pkg::pix_t p);
        while ($urandom_range(99) < src_idle)
        begin
            @(negedge clk);
            pix_ch.valid = 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        pix_ch.valid    = 1'b1;
        pix_ch.func     = f;
        pix_ch.keep     = p.keep;
        pix_ch.red_in   = p.red;
        pix_ch.green_in = p.green;
        pix_ch.blue_in  = p.blue;
        do
            @(posedge clk);
        while (!pix_ch.ready);
    endtask

    task automatic await_results();
        @(negedge clk);
        pix_ch.valid = 1'b0;
        while (board.blurred_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        await_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [mbb_pkg::SIZE_W-1:0] v);
        settle();
        @(negedge clk);
        cfg_ch.valid      = 1'b1;
        cfg_ch.image_size = v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // one frame: pixels with stray drain beats, then the drain tail with stray pixels
    task automatic run_frame(input int unsigned n, input bit cut, input bit pause);
        int unsigned total, stop_at, pause_at;
        total    = n * n + n + 1;
        stop_at  = cut ? $urandom_range(total - 1, 1) : total;
        pause_at = pause ? $urandom_range(total - 1, 1) : total;
        for (int unsigned k = 0; k < stop_at; k++)
        begin
            if (k == pause_at)
                await_results();
            if (k < n * n)
            begin
                if ($urandom_range(9) == 0)
                    send_item(mbb_pkg::FUNC_DRAIN, rand_pixel());
                send_item(mbb_pkg::FUNC_PIXEL, rand_pixel());
            end
            else if ($urandom_range(2) == 0)
                send_item(mbb_pkg::FUNC_PIXEL, rand_pixel());
            else
                send_item(mbb_pkg::FUNC_DRAIN, rand_pixel());
        end
    endtask

    initial
    begin
        int unsigned goal;
        bit          must_write, first;
        logic [mbb_pkg::SIZE_W-1:0] v;

        rst_n             = 1'b0;
        pix_ch.valid      = 1'b0;
        pix_ch.func       = mbb_pkg::FUNC_PIXEL;
        pix_ch.keep       = 1'b0;
        pix_ch.red_in     = '0;
        pix_ch.green_in   = '0;
        pix_ch.blue_in    = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.image_size = '0;
        res_ch.ready      = 1'b0;
        src_idle          = 33;
        snk_idle          = 54;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset width: nothing comes out within the first line of a full-width frame
        for (int k = 0; k < WIDE_BEATS; k++)
            send_item(mbb_pkg::FUNC_PIXEL, rand_pixel());

        // 3x3 frame: corners, edges, center, keep, early drain, late pixel
        write_size(mbb_pkg::SIZE_W'(3));
        send_item(mbb_pkg::FUNC_DRAIN, rand_pixel());
        send_item(mbb_pkg::FUNC_PIXEL, {1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_item(mbb_pkg::FUNC_PIXEL, {1'b0, 16'h0000, 16'h0000, 16'h0000});
        send_item(mbb_pkg::FUNC_PIXEL, {1'b1, 16'hFFFF, 16'h0000, 16'h8000});
        send_item(mbb_pkg::FUNC_PIXEL, {1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_item(mbb_pkg::FUNC_PIXEL, {1'b0, 16'h0001, 16'hFFFE, 16'h7FFF});
        send_item(mbb_pkg::FUNC_PIXEL, {1'b1, 16'h0000, 16'hFFFF, 16'h1234});
        send_item(mbb_pkg::FUNC_PIXEL, {1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_item(mbb_pkg::FUNC_PIXEL, {1'b0, 16'h0000, 16'h0000, 16'h0000});
        send_item(mbb_pkg::FUNC_PIXEL, {1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_item(mbb_pkg::FUNC_DRAIN, rand_pixel());
        send_item(mbb_pkg::FUNC_PIXEL, rand_pixel());
        send_item(mbb_pkg::FUNC_DRAIN, rand_pixel());
        send_item(mbb_pkg::FUNC_DRAIN, rand_pixel());

        // size below range acts as 2
        write_size(mbb_pkg::SIZE_W'(1));
        send_item(mbb_pkg::FUNC_PIXEL, {1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_item(mbb_pkg::FUNC_PIXEL, {1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_item(mbb_pkg::FUNC_PIXEL, {1'b1, 16'h0000, 16'h0000, 16'h0000});
        send_item(mbb_pkg::FUNC_PIXEL, {1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_item(mbb_pkg::FUNC_DRAIN, rand_pixel());
        send_item(mbb_pkg::FUNC_DRAIN, rand_pixel());
        send_item(mbb_pkg::FUNC_DRAIN, rand_pixel());

        // size above range acts as MAX_SIZE
        write_size('1);
        for (int k = 0; k < WIDE_BEATS; k++)
            send_item(mbb_pkg::FUNC_PIXEL, rand_pixel());

        for (int m = 0; m < 3; m++)
        begin
            src_idle   = (m == 0) ? 33 : (m == 1) ? 54 : 0;
            snk_idle   = (m == 0) ? 54 : (m == 1) ? 33 : 0;
            goal       = board.beats + BEATS_PER_STRETCH;
            must_write = 1'b1;
            first      = 1'b1;
            while (board.beats < goal)
            begin
                if (must_write || $urandom_range(1) == 1)
                begin
                    if (first)
                        v = mbb_pkg::SIZE_W'(12);
                    else
                    begin
                        case ($urandom_range(9))
                            0: v = mbb_pkg::SIZE_W'($urandom_range(1));
                            1: v = mbb_pkg::SIZE_W'(2);
                            default: v = mbb_pkg::SIZE_W'($urandom_range(12, 2));
                        endcase
                    end
                    write_size(v);
                end
                if (first)
                begin
                    @(posedge clk);
                    hold_left = HOLD_CYCLES;
                end
                must_write = ($urandom_range(7) == 0);
                run_frame(board.side(), must_write && !first,
                          !first && $urandom_range(3) == 0);
                first = 1'b0;
            end
        end

        settle();
        $display("Checked %0d results from %0d beats (%0d stray drains ignored), %0d frames closed",
                 board.checked, board.beats, board.ignored, board.frames);
        $display("Sizes: first line of 1024 and 2047, 0/1 clamped, directed 3, random 2..12, three stall mixes");
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/mbb_pkg.sv
hw/rtl/mbb_if.sv
hw/rtl/mbb_line_mem.sv
hw/rtl/mbb_div.sv
hw/rtl/masked_box_blur_3x3.sv
tb/sv/tb.sv
